FILE: sv/lcgh_pkg.sv
// Shared types, constants and helper functions of the generator with histogram.
package lcgh_pkg;

  // Field and datapath widths.
  localparam int ValW      = 31;
  localparam int CntW      = 32;
  localparam int OpW       = 2;
  localparam int SelW      = 4;
  localparam int BinFieldW = 4;
  localparam int CfgIdxW   = 2;

  // Number of histogram bins.
  localparam int SPAN    = 16;
  localparam int BinW    = $clog2(SPAN);
  localparam int AccW    = ValW + BinW;
  localparam int SumW    = ValW + 1;
  localparam int ProdW   = ValW + SumW;
  localparam int DivCntW = $clog2(ProdW);

  // Microprogram addressing.
  localparam int StepW = 4;
  localparam logic [StepW-1:0] STEP_IDLE       = StepW'(0);
  localparam logic [StepW-1:0] STEP_RESTART    = StepW'(1);
  localparam logic [StepW-1:0] STEP_READ       = StepW'(2);
  localparam logic [StepW-1:0] STEP_BAD        = StepW'(3);
  localparam logic [StepW-1:0] STEP_BIN_INIT   = StepW'(4);
  localparam logic [StepW-1:0] STEP_BIN_TEST   = StepW'(5);
  localparam logic [StepW-1:0] STEP_BIN_UPDATE = StepW'(6);
  localparam logic [StepW-1:0] STEP_DIV        = StepW'(7);
  localparam logic [StepW-1:0] STEP_ADVANCE    = StepW'(8);
  localparam logic [StepW-1:0] STEP_EMIT       = StepW'(9);

  // Item operation codes.
  typedef enum logic [OpW-1:0] {
    OP_RESTART = 2'd0,
    OP_STEP    = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_MULTIPLIER = 2'd0,
    REG_INCREMENT  = 2'd1,
    REG_MODULUS    = 2'd2,
    REG_SEED       = 2'd3
  } cfg_reg_e;

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    U_NOP,
    U_IDLE,
    U_RESTART,
    U_READ,
    U_ZERO,
    U_BIN_INIT,
    U_BIN_TEST,
    U_BIN_UPDATE,
    U_DIV_STEP,
    U_ADVANCE,
    U_EMIT
  } uop_e;

  // Sequencer jump conditions.
  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_DISPATCH,
    J_LOOP_SEARCH,
    J_LOOP_DIV,
    J_WAIT_FREE
  } jcond_e;

  // One control word of the microprogram.
  typedef struct packed {
    uop_e             uop;
    jcond_e           jcond;
    logic [StepW-1:0] target;
  } ctrl_word_t;

  // Status flags raised by the datapath.
  typedef struct packed {
    logic search_done;
    logic div_done;
  } dp_status_t;

  // Everything the sequencer branches on.
  typedef struct packed {
    logic       accept;
    op_e        opcode;
    logic       out_free;
    dp_status_t dp;
  } seq_status_t;

  // One result item.
  typedef struct packed {
    logic [ValW-1:0]      value;
    logic [BinFieldW-1:0] bin;
    logic [CntW-1:0]      count;
    logic                 oor;
  } result_t;

  // Entry step of the microprogram for each operation.
  function automatic logic [StepW-1:0] dispatch_target(input op_e op);
    logic [StepW-1:0] t;
    t = STEP_BAD;
    unique case (op)
      OP_RESTART: t = STEP_RESTART;
      OP_STEP:    t = STEP_BIN_INIT;
      OP_READ:    t = STEP_READ;
      default:    t = STEP_BAD;
    endcase
    return t;
  endfunction

  // Low bits of a bin number as carried in the result item.
  function automatic logic [BinFieldW-1:0] to_bin_field(input logic [BinW-1:0] j);
    logic [BinW+BinFieldW-1:0] t;
    t = {{BinFieldW{1'b0}}, j};
    return t[BinFieldW-1:0];
  endfunction

endpackage

FILE: sv/lcg_with_histogram.sv
// Top level of the linear congruential generator with a sixteen-bin histogram.
//
// One item is taken at a time. A restart or read item runs its own step, then the
// emit step that loads the output register; a step item runs the bin init step,
// a bin search over B bins (1 to 16), the bin update, the modulo loop and the
// advance step before the emit step, in the order set by the microcoded sequencer:
// the bin search steps one bin per cycle and the 63-bit product is reduced by the
// modulus one bit per cycle in a restoring remainder loop. A finished result sits
// in an output register, so the next item is accepted while it waits to be taken.
module lcg_with_histogram import lcgh_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [ValW-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OpW-1:0]       opcode_i,
  input  logic [SelW-1:0]      bin_select_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ValW-1:0]      value_o,
  output logic [BinFieldW-1:0] bin_o,
  output logic [CntW-1:0]      bin_count_o,
  output logic                 out_of_range_o
);

  ctrl_word_t  ctrl;
  seq_status_t seq_status;
  dp_status_t  dp_status;
  result_t     result;
  logic        idle;
  logic        in_accept;
  logic        out_free;
  logic        out_load;

  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  // Input handshake: items enter only at the idle step.
  assign in_stall_o = !idle;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Output register is free when empty or being taken this cycle.
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (ctrl.uop == U_EMIT) && out_free;

  // Status gathered for the sequencer.
  always_comb begin
    seq_status.accept   = in_accept;
    seq_status.opcode   = op_e'(opcode_i);
    seq_status.out_free = out_free;
    seq_status.dp       = dp_status;
  end

  lcgh_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (seq_status),
    .ctrl_o   (ctrl),
    .idle_o   (idle)
  );

  lcgh_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (in_accept),
    .bin_select_i (bin_select_i),
    .ctrl_i       (ctrl),
    .status_o     (dp_status),
    .result_o     (result)
  );

  // Output register next values.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = out_q.value;
  assign bin_o          = out_q.bin;
  assign bin_count_o    = out_q.count;
  assign out_of_range_o = out_q.oor;

  // An accepted item always leaves the idle step.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !idle)
    else $error("sequencer stayed idle after accepting an item");

  // An out-of-range result carries no bin and no count.
  a_oor_no_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (bin_o == '0 && bin_count_o == '0))
    else $error("out-of-range result carries a bin or count");

  // A value can only exceed the largest coefficient if it is non-zero.
  a_oor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (value_o != '0))
    else $error("zero value flagged out of range");

endmodule

FILE: sv/lcgh_seq.sv
// Microprogram sequencer: step counter, control store and jump logic.
module lcgh_seq import lcgh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  seq_status_t status_i,
  output ctrl_word_t  ctrl_o,
  output logic        idle_o
);

  logic [StepW-1:0] step_q, step_d;

  // Control store: one word per microprogram step.
  function automatic ctrl_word_t rom_word(input logic [StepW-1:0] s);
    ctrl_word_t w;
    w = '{uop: U_NOP, jcond: J_GOTO, target: STEP_IDLE};
    unique case (s)
      STEP_IDLE:       w = '{uop: U_IDLE,       jcond: J_DISPATCH,    target: STEP_IDLE};
      STEP_RESTART:    w = '{uop: U_RESTART,    jcond: J_GOTO,        target: STEP_EMIT};
      STEP_READ:       w = '{uop: U_READ,       jcond: J_GOTO,        target: STEP_EMIT};
      STEP_BAD:        w = '{uop: U_ZERO,       jcond: J_GOTO,        target: STEP_EMIT};
      STEP_BIN_INIT:   w = '{uop: U_BIN_INIT,   jcond: J_NEXT,        target: STEP_IDLE};
      STEP_BIN_TEST:   w = '{uop: U_BIN_TEST,   jcond: J_LOOP_SEARCH, target: STEP_BIN_TEST};
      STEP_BIN_UPDATE: w = '{uop: U_BIN_UPDATE, jcond: J_NEXT,        target: STEP_IDLE};
      STEP_DIV:        w = '{uop: U_DIV_STEP,   jcond: J_LOOP_DIV,    target: STEP_DIV};
      STEP_ADVANCE:    w = '{uop: U_ADVANCE,    jcond: J_NEXT,        target: STEP_IDLE};
      STEP_EMIT:       w = '{uop: U_EMIT,       jcond: J_WAIT_FREE,   target: STEP_IDLE};
      default:         w = '{uop: U_NOP,        jcond: J_GOTO,        target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // Output decode: the current control word.
  always_comb begin
    ctrl_o = rom_word(step_q);
    idle_o = (step_q == STEP_IDLE);
  end

  // Next step selection.
  always_comb begin
    step_d = step_q;
    unique case (ctrl_o.jcond)
      J_NEXT:        step_d = step_q + 1'b1;
      J_GOTO:        step_d = ctrl_o.target;
      J_DISPATCH: begin
        if (status_i.accept) step_d = dispatch_target(status_i.opcode);
      end
      J_LOOP_SEARCH: step_d = status_i.dp.search_done ? step_q + 1'b1 : ctrl_o.target;
      J_LOOP_DIV:    step_d = status_i.dp.div_done ? step_q + 1'b1 : ctrl_o.target;
      J_WAIT_FREE: begin
        if (status_i.out_free) step_d = ctrl_o.target;
      end
      default:       step_d = STEP_IDLE;
    endcase
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: sv/lcgh_datapath.sv
// Datapath: configuration, current value, histogram, bin search and serial modulo.
module lcgh_datapath import lcgh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ValW-1:0]    cfg_data_i,
  input  logic               accept_i,
  input  logic [SelW-1:0]    bin_select_i,
  input  ctrl_word_t         ctrl_i,
  output dp_status_t         status_o,
  output result_t            result_o
);

  // Configuration registers.
  logic [ValW-1:0] mult_q, mult_d;
  logic [ValW-1:0] inc_q, inc_d;
  logic [ValW-1:0] mod_q, mod_d;
  logic [ValW-1:0] seed_q, seed_d;

  // Generator state and histogram.
  logic [ValW-1:0] cur_q, cur_d;
  logic [CntW-1:0] bins_q [SPAN];
  logic [CntW-1:0] bins_d [SPAN];

  // Working registers.
  logic [SelW-1:0]    sel_q, sel_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [AccW-1:0]    lhs_q, lhs_d;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [BinW-1:0]    j_q, j_d;
  logic               found_q, found_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [ValW-1:0]    wrap_q, wrap_d;
  logic [ValW-1:0]    rem_q, rem_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  result_t            res_q, res_d;

  // Combinational helpers.
  logic [ValW-1:0]      coef_max;
  logic                 hit;
  logic                 last_bin;
  logic [CntW-1:0]      cnt_next;
  logic [ProdW-1:0]     prod_full;
  logic [ValW:0]        div_cat;
  logic [ValW:0]        div_diff;
  logic                 div_ge;
  logic [BinW+SelW-1:0] sel_wide;

  // Largest of the three coefficients.
  always_comb begin
    coef_max = mult_q;
    if (inc_q > coef_max) coef_max = inc_q;
    if (mod_q > coef_max) coef_max = mod_q;
  end

  // Bin search compare, saturating count and one restoring-remainder step.
  assign hit       = (lhs_q <= acc_q);
  assign last_bin  = (j_q == BinW'(SPAN - 1));
  assign cnt_next  = (bins_q[j_q] == {CntW{1'b1}}) ? bins_q[j_q] : bins_q[j_q] + 1'b1;
  assign prod_full = ProdW'(mult_q) * ProdW'(sum_q);
  assign div_cat   = {rem_q, prod_q[ProdW-1]};
  assign div_ge    = (div_cat >= {1'b0, mod_q});
  assign div_diff  = div_cat - {1'b0, mod_q};
  assign sel_wide  = {{BinW{1'b0}}, sel_q};

  assign status_o.search_done = hit || last_bin;
  assign status_o.div_done    = (dcnt_q == DivCntW'(ProdW - 1));
  assign result_o             = res_q;

  // Micro-operation decode.
  always_comb begin
    mult_d  = mult_q;
    inc_d   = inc_q;
    mod_d   = mod_q;
    seed_d  = seed_q;
    cur_d   = cur_q;
    bins_d  = bins_q;
    sel_d   = sel_q;
    sum_d   = sum_q;
    lhs_d   = lhs_q;
    acc_d   = acc_q;
    j_d     = j_q;
    found_d = found_q;
    prod_d  = prod_q;
    wrap_d  = wrap_q;
    rem_d   = rem_q;
    dcnt_d  = dcnt_q;
    res_d   = res_q;

    unique case (ctrl_i.uop)
      U_IDLE: begin
        if (accept_i) sel_d = bin_select_i;
      end
      U_RESTART: begin
        cur_d = seed_q;
        for (int i = 0; i < SPAN; i++) bins_d[i] = '0;
        res_d = '0;
      end
      U_READ: begin
        res_d     = '0;
        res_d.bin = sel_q;
        if (sel_wide < (BinW + SelW)'(SPAN)) res_d.count = bins_q[sel_wide[BinW-1:0]];
      end
      U_ZERO: begin
        res_d = '0;
      end
      U_BIN_INIT: begin
        lhs_d = AccW'(cur_q) * AccW'(SPAN);
        acc_d = AccW'(coef_max);
        j_d   = '0;
        sum_d = SumW'(cur_q) + SumW'(inc_q);
      end
      U_BIN_TEST: begin
        found_d = hit;
        if (!hit && !last_bin) begin
          j_d   = j_q + 1'b1;
          acc_d = acc_q + AccW'(coef_max);
        end
      end
      U_BIN_UPDATE: begin
        res_d       = '0;
        res_d.value = cur_q;
        if (found_q) begin
          bins_d[j_q] = cnt_next;
          res_d.bin   = to_bin_field(j_q);
          res_d.count = cnt_next;
        end else begin
          res_d.oor = 1'b1;
        end
        prod_d = prod_full;
        wrap_d = prod_full[ValW-1:0];
        rem_d  = '0;
        dcnt_d = '0;
      end
      U_DIV_STEP: begin
        prod_d = prod_q << 1;
        rem_d  = div_ge ? div_diff[ValW-1:0] : div_cat[ValW-1:0];
        dcnt_d = dcnt_q + 1'b1;
      end
      U_ADVANCE: begin
        cur_d = (mod_q == '0) ? wrap_q : rem_q;
      end
      default: begin
      end
    endcase

    // Register writes are for the user to make only while idle; the block does not enforce it.
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MULTIPLIER: mult_d = cfg_data_i;
        REG_INCREMENT:  inc_d  = cfg_data_i;
        REG_MODULUS:    mod_d  = cfg_data_i;
        REG_SEED:       seed_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Configuration, current value and histogram.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= ValW'(1);
      inc_q  <= '0;
      mod_q  <= ValW'(1);
      seed_q <= '0;
      cur_q  <= '0;
      for (int i = 0; i < SPAN; i++) bins_q[i] <= '0;
    end else begin
      mult_q <= mult_d;
      inc_q  <= inc_d;
      mod_q  <= mod_d;
      seed_q <= seed_d;
      cur_q  <= cur_d;
      bins_q <= bins_d;
    end
  end

  // Working registers hold payload only.
  always_ff @(posedge clk_i) begin
    sel_q   <= sel_d;
    sum_q   <= sum_d;
    lhs_q   <= lhs_d;
    acc_q   <= acc_d;
    j_q     <= j_d;
    found_q <= found_d;
    prod_q  <= prod_d;
    wrap_q  <= wrap_d;
    rem_q   <= rem_d;
    dcnt_q  <= dcnt_d;
    res_q   <= res_d;
  end

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the linear congruential generator with histogram.
`timescale 1ns / 1ps

import lcgh_pkg::*;

// Tracks generator state and bin counts and holds the expected result items in order.
class lcg_histogram_model;
  logic [ValW-1:0] multiplier;
  logic [ValW-1:0] increment;
  logic [ValW-1:0] modulus;
  logic [ValW-1:0] seed_value;
  logic [ValW-1:0] current_value;
  logic [CntW-1:0] bin_counts [SPAN];
  result_t         expected_results [$];
  int              errors;

  function new();
    multiplier    = ValW'(1);
    increment     = '0;
    modulus       = ValW'(1);
    seed_value    = '0;
    current_value = '0;
    errors        = 0;
    foreach (bin_counts[i]) bin_counts[i] = '0;
  endfunction

  // Mirrors a register write made while the block is idle.
  function void set_reg(cfg_reg_e idx, logic [ValW-1:0] data);
    case (idx)
      REG_MULTIPLIER: multiplier = data;
      REG_INCREMENT:  increment  = data;
      REG_MODULUS:    modulus    = data;
      REG_SEED:       seed_value = data;
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // Works out the result of one accepted item and updates the state.
  function void note_item(op_e op, logic [SelW-1:0] sel);
    result_t     res;
    logic [63:0] largest;
    logic [63:0] scaled;
    logic [63:0] product;
    int          hit_bin;
    res = '0;
    case (op)
      OP_RESTART: begin
        current_value = seed_value;
        foreach (bin_counts[i]) bin_counts[i] = '0;
      end
      OP_STEP: begin
        largest = 64'(multiplier);
        if (increment > largest[ValW-1:0]) largest = 64'(increment);
        if (modulus > largest[ValW-1:0]) largest = 64'(modulus);
        scaled  = 64'(current_value) * 64'(SPAN);
        hit_bin = -1;
        for (int j = 0; j < SPAN; j++) begin
          if (hit_bin < 0 && scaled <= 64'(j + 1) * largest) hit_bin = j;
        end
        res.value = current_value;
        if (hit_bin >= 0) begin
          // Counts saturate at all ones.
          if (bin_counts[hit_bin] != '1) bin_counts[hit_bin] = bin_counts[hit_bin] + 1'b1;
          res.bin   = BinFieldW'(hit_bin);
          res.count = bin_counts[hit_bin];
        end else begin
          res.oor = 1'b1;
        end
        product = 64'(multiplier) * (64'(current_value) + 64'(increment));
        if (modulus == '0) current_value = product[ValW-1:0];
        else current_value = ValW'(product % 64'(modulus));
      end
      OP_READ: begin
        res.bin = BinFieldW'(sel);
        if (int'(sel) < SPAN) res.count = bin_counts[sel];
      end
      default: ;
    endcase
    expected_results.push_back(res);
  endfunction

  // Compares one accepted result item with the oldest expectation.
  function void check_item(logic [ValW-1:0] value, logic [BinFieldW-1:0] bin_num,
                           logic [CntW-1:0] count, logic oor);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result item arrived with none expected");
      errors++;
      return;
    end
    want = expected_results.pop_front();
    if (value !== want.value) begin
      $error("value: expected %0d, actual %0d", want.value, value);
      errors++;
    end
    if (bin_num !== want.bin) begin
      $error("bin: expected %0d, actual %0d", want.bin, bin_num);
      errors++;
    end
    if (count !== want.count) begin
      $error("bin_count: expected %0d, actual %0d", want.count, count);
      errors++;
    end
    if (oor !== want.oor) begin
      $error("out_of_range: expected %0d, actual %0d", want.oor, oor);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam logic [ValW-1:0] VAL_MAX    = {ValW{1'b1}};
  localparam int              RAND_ITEMS = 400;
  localparam int              SETTLE     = 100;
  localparam int              CYCLE_CAP  = 500000;

  logic                 clk_i;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i    = '0;
  logic [ValW-1:0]      cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [OpW-1:0]       opcode_i       = '0;
  logic [SelW-1:0]      bin_select_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [ValW-1:0]      value_o;
  logic [BinFieldW-1:0] bin_o;
  logic [CntW-1:0]      bin_count_o;
  logic                 out_of_range_o;

  lcg_histogram_model hist_model = new();
  bit                 quiet_stretch = 1'b0;
  int                 cycle_count   = 0;

  lcg_with_histogram u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .bin_select_i   (bin_select_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_o        (value_o),
    .bin_o          (bin_o),
    .bin_count_o    (bin_count_o),
    .out_of_range_o (out_of_range_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver stalls about a third of the time, except during the quiet stretch.
  always @(posedge clk_i) begin
    out_stall_i <= quiet_stretch ? 1'b0 : ($urandom_range(99, 0) < 33);
  end

  // Observes both handshakes at each edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) hist_model.note_item(op_e'(opcode_i), bin_select_i);
      if (out_valid_o && !out_stall_i)
        hist_model.check_item(value_o, bin_o, bin_count_o, out_of_range_o);
    end
  end

  // Presents one item after a random gap and holds it until it is accepted.
  task automatic send_item(op_e op, logic [SelW-1:0] sel);
    int gap;
    gap = 0;
    if (!quiet_stretch) begin
      while (gap < 20 && $urandom_range(99, 0) < 33) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    bin_select_i <= sel;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops sending and waits for every expected result item, then settles.
  task automatic drain_results(int settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (hist_model.pending() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // One register write; the enable is lowered by the caller.
  task automatic write_reg(cfg_reg_e idx, logic [ValW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    hist_model.set_reg(idx, data);
  endtask

  // Writes all four registers while the block is idle.
  task automatic load_config(logic [ValW-1:0] mult, logic [ValW-1:0] incr,
                             logic [ValW-1:0] modl, logic [ValW-1:0] seed_val);
    write_reg(REG_MULTIPLIER, mult);
    write_reg(REG_INCREMENT, incr);
    write_reg(REG_MODULUS, modl);
    write_reg(REG_SEED, seed_val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Main stimulus.
  initial begin
    logic [ValW-1:0] mult;
    logic [ValW-1:0] incr;
    logic [ValW-1:0] modl;
    logic [ValW-1:0] seed_val;
    int              sent;
    int              phase_len;
    int              pick;
    op_e             op;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Reset settings: everything lands in bin zero; also a read of the top bin
    // and an unused opcode.
    send_item(OP_STEP, 4'h0);
    send_item(OP_STEP, 4'hF);
    send_item(OP_READ, 4'h0);
    send_item(OP_READ, 4'hF);
    send_item(OP_NONE, 4'hF);
    send_item(OP_RESTART, 4'h0);
    drain_results(2);

    // All registers at their largest: the first value falls in the top bin.
    load_config(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
    send_item(OP_RESTART, 4'hA);
    send_item(OP_STEP, 4'h5);
    send_item(OP_STEP, 4'h0);
    send_item(OP_STEP, 4'hF);
    send_item(OP_READ, 4'hF);
    send_item(OP_READ, 4'h0);
    drain_results(2);

    // A seed above the largest coefficient is flagged and not counted.
    load_config(ValW'(5), ValW'(3), ValW'(7), VAL_MAX);
    send_item(OP_RESTART, 4'h0);
    send_item(OP_STEP, 4'h0);
    send_item(OP_STEP, 4'h0);
    send_item(OP_STEP, 4'h0);
    send_item(OP_READ, 4'h6);
    drain_results(2);

    // A seed exactly at the largest coefficient sits on the top bin boundary.
    load_config(ValW'(3), ValW'(1), ValW'(16), ValW'(16));
    send_item(OP_RESTART, 4'h0);
    send_item(OP_STEP, 4'h0);
    send_item(OP_STEP, 4'h0);
    send_item(OP_STEP, 4'h0);
    send_item(OP_READ, 4'h9);
    drain_results(2);

    // Random phases, each with its own settings, opened by a restart.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      pick = $urandom_range(3, 0);
      case (pick)
        0: begin
          modl     = ValW'($urandom_range(200, 2));
          mult     = ValW'($urandom_range(modl, 1));
          incr     = ValW'($urandom_range(modl, 0));
          seed_val = ValW'($urandom_range(modl + 40, 0));
        end
        1: begin
          mult     = ValW'($urandom_range(VAL_MAX, 1));
          incr     = ValW'($urandom);
          modl     = ValW'($urandom_range(VAL_MAX, 1));
          seed_val = ValW'($urandom);
        end
        2: begin
          mult     = $urandom_range(1, 0) ? VAL_MAX : ValW'(1);
          incr     = $urandom_range(1, 0) ? VAL_MAX : '0;
          modl     = $urandom_range(1, 0) ? VAL_MAX : ValW'(1);
          seed_val = $urandom_range(1, 0) ? VAL_MAX : '0;
        end
        default: begin
          mult     = ValW'($urandom_range(VAL_MAX, 1));
          incr     = ValW'($urandom_range(1000, 0));
          modl     = ValW'($urandom_range(1000, 1));
          seed_val = ValW'($urandom);
        end
      endcase
      load_config(mult, incr, modl, seed_val);

      phase_len = $urandom_range(50, 15);
      send_item(OP_RESTART, SelW'($urandom_range(15, 0)));
      sent++;
      for (int k = 1; k < phase_len; k++) begin
        quiet_stretch = (sent >= 120 && sent < 200);
        pick = $urandom_range(99, 0);
        if (pick < 68) op = OP_STEP;
        else if (pick < 88) op = OP_READ;
        else if (pick < 97) op = OP_RESTART;
        else op = OP_NONE;
        send_item(op, SelW'($urandom_range(15, 0)));
        if (op != OP_NONE) sent++;
      end
      quiet_stretch = 1'b0;
      // The sender holds off until every result of the phase has come.
      drain_results(2);
    end

    drain_results(SETTLE);
    if (hist_model.errors == 0 && hist_model.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
